// ===== src/sha1ds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1ds_pkg
// Shared constants and controller-to-datapath types for the SHA-1 stream core.
// ----------------------------------------------------------------------------
package sha1ds_pkg;

	// initial hash value
	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	// round constants, one per group of twenty rounds
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	// first padding byte
	localparam logic [7:0] PAD_MARK = 8'h80;

	// byte source for a buffer write
	localparam logic [1:0] BSEL_INPUT = 2'd0;
	localparam logic [1:0] BSEL_MARK  = 2'd1;
	localparam logic [1:0] BSEL_ZERO  = 2'd2;
	localparam logic [1:0] BSEL_LEN   = 2'd3;

	// round groups
	localparam logic [1:0] GRP_CH  = 2'd0;
	localparam logic [1:0] GRP_P1  = 2'd1;
	localparam logic [1:0] GRP_MAJ = 2'd2;
	localparam logic [1:0] GRP_P2  = 2'd3;

	localparam int ROUNDS    = 80;
	localparam int DIG_WORDS = 5;

	// commands from controller to datapath
	typedef struct packed {
		logic       put_byte;
		logic [1:0] byte_sel;
		logic       count_byte;
		logic       round;
		logic       round_first;
		logic [1:0] round_grp;
		logic       hash_add;
		logic       reinit;
		logic [2:0] word_sel;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [5:0] fill;
	} status_t;

endpackage

// ===== src/sha1ds_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1ds_ctrl
// Sequencer: byte intake, padding, round counting and digest readout.
// ----------------------------------------------------------------------------
module sha1ds_ctrl import sha1ds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       has_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] word_index,
	output logic       is_last_word,
	output cmd_t       cmd,
	input  status_t    status
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROUND = 3'd1;
	localparam logic [2:0] S_FINAL = 3'd2;
	localparam logic [2:0] S_PAD   = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
	localparam logic [2:0] LAST_WORD  = 3'(DIG_WORDS - 1);
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] FILL_END   = 6'd63;

	logic [2:0] state_q, state_d;
	logic [6:0] round_q, round_d;
	logic [2:0] word_q, word_d;
	logic       finish_q, finish_d;
	logic       sent80_q, sent80_d;
	logic       lenph_q, lenph_d;
	logic       done_q, done_d;
	logic       fill_end;

	assign fill_end     = (status.fill == FILL_END);
	assign word_index   = word_q;
	assign is_last_word = (word_q == LAST_WORD);

	// next state and commands
	always_comb begin
		state_d   = state_q;
		round_d   = round_q;
		word_d    = word_q;
		finish_d  = finish_q;
		sent80_d  = sent80_q;
		lenph_d   = lenph_q;
		done_d    = done_q;
		cmd       = '0;
		cmd.word_sel = word_q;
		in_stall  = (state_q != S_IDLE);
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					finish_d = last_byte;
					if (has_byte) begin
						cmd.put_byte   = 1'b1;
						cmd.byte_sel   = BSEL_INPUT;
						cmd.count_byte = 1'b1;
					end
					if (has_byte && fill_end) begin
						state_d = S_ROUND;
					end else if (last_byte) begin
						state_d = S_PAD;
					end
				end
			end
			S_ROUND: begin
				cmd.round       = 1'b1;
				cmd.round_first = (round_q == 7'd0);
				if (round_q < 7'd20) begin
					cmd.round_grp = GRP_CH;
				end else if (round_q < 7'd40) begin
					cmd.round_grp = GRP_P1;
				end else if (round_q < 7'd60) begin
					cmd.round_grp = GRP_MAJ;
				end else begin
					cmd.round_grp = GRP_P2;
				end
				if (round_q == LAST_ROUND) begin
					round_d = 7'd0;
					state_d = S_FINAL;
				end else begin
					round_d = round_q + 7'd1;
				end
			end
			S_FINAL: begin
				cmd.hash_add = 1'b1;
				if (!finish_q) begin
					state_d = S_IDLE;
				end else if (done_q) begin
					state_d = S_OUT;
				end else begin
					state_d = S_PAD;
				end
			end
			S_PAD: begin
				cmd.put_byte = 1'b1;
				if (!sent80_q) begin
					// marker byte; length field may follow in this block or the next
					cmd.byte_sel = BSEL_MARK;
					sent80_d     = 1'b1;
					lenph_d      = (status.fill < LEN_POS) || fill_end;
				end else if (lenph_q && (status.fill >= LEN_POS)) begin
					cmd.byte_sel = BSEL_LEN;
					if (fill_end) begin
						done_d = 1'b1;
					end
				end else begin
					cmd.byte_sel = BSEL_ZERO;
					if (fill_end) begin
						lenph_d = 1'b1;
					end
				end
				if (fill_end) begin
					state_d = S_ROUND;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (word_q == LAST_WORD) begin
						cmd.reinit = 1'b1;
						word_d     = 3'd0;
						finish_d   = 1'b0;
						sent80_d   = 1'b0;
						lenph_d    = 1'b0;
						done_d     = 1'b0;
						state_d    = S_IDLE;
					end else begin
						word_d = word_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			round_q  <= 7'd0;
			word_q   <= 3'd0;
			finish_q <= 1'b0;
			sent80_q <= 1'b0;
			lenph_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			round_q  <= round_d;
			word_q   <= word_d;
			finish_q <= finish_d;
			sent80_q <= sent80_d;
			lenph_q  <= lenph_d;
			done_q   <= done_d;
		end
	end

endmodule

// ===== src/sha1ds_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1ds_datapath
// Block shift buffer doubling as message schedule window, round unit,
// hash words, fill and length counters.
// ----------------------------------------------------------------------------
module sha1ds_datapath import sha1ds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  cmd_t        cmd,
	output status_t     status,
	output logic [31:0] digest_word
);

	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [63:0]  total_q;
	logic [31:0]  h_q [DIG_WORDS];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;

	logic [63:0]  bit_len;
	logic [63:0]  len_shift;
	logic [7:0]   put_val;
	logic [31:0]  sa, sb, sc, sd, se;
	logic [31:0]  f_val, k_val, w_t, w_new, tmp;

	assign status.fill = fill_q;

	// length byte for the current fill position, most significant first
	assign bit_len   = {total_q[60:0], 3'b000};
	assign len_shift = bit_len >> {~fill_q[2:0], 3'b000};

	always_comb begin
		unique case (cmd.byte_sel)
			BSEL_INPUT: put_val = data_byte;
			BSEL_MARK:  put_val = PAD_MARK;
			BSEL_ZERO:  put_val = 8'h00;
			BSEL_LEN:   put_val = len_shift[7:0];
			default:    put_val = 8'h00;
		endcase
	end

	// round inputs: first round starts from the hash words
	assign sa = cmd.round_first ? h_q[0] : a_q;
	assign sb = cmd.round_first ? h_q[1] : b_q;
	assign sc = cmd.round_first ? h_q[2] : c_q;
	assign sd = cmd.round_first ? h_q[3] : d_q;
	assign se = cmd.round_first ? h_q[4] : e_q;

	always_comb begin
		unique case (cmd.round_grp)
			GRP_CH: begin
				f_val = (sb & sc) | (~sb & sd);
				k_val = K0;
			end
			GRP_P1: begin
				f_val = sb ^ sc ^ sd;
				k_val = K1;
			end
			GRP_MAJ: begin
				f_val = (sb & sc) | (sb & sd) | (sc & sd);
				k_val = K2;
			end
			GRP_P2: begin
				f_val = sb ^ sc ^ sd;
				k_val = K3;
			end
			default: begin
				f_val = sb ^ sc ^ sd;
				k_val = K3;
			end
		endcase
	end

	// schedule window: oldest word on top, taps at t-16, t-14, t-8, t-3
	assign w_t   = blk_q[511:480];
	assign w_new = {w_t[30:0] ^ blk_q[446:416] ^ blk_q[254:224] ^ blk_q[94:64],
	                w_t[31] ^ blk_q[447] ^ blk_q[255] ^ blk_q[95]};
	assign tmp   = {sa[26:0], sa[31:27]} + f_val + se + k_val + w_t;

	// buffer and working variables
	always_ff @(posedge clk) begin
		if (cmd.put_byte) begin
			blk_q <= {blk_q[503:0], put_val};
		end else if (cmd.round) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (cmd.round) begin
			a_q <= tmp;
			b_q <= sa;
			c_q <= {sb[1:0], sb[31:2]};
			d_q <= sc;
			e_q <= sd;
		end
	end

	// hash words and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0]  <= IV0;
			h_q[1]  <= IV1;
			h_q[2]  <= IV2;
			h_q[3]  <= IV3;
			h_q[4]  <= IV4;
			fill_q  <= 6'd0;
			total_q <= 64'd0;
		end else if (cmd.reinit) begin
			h_q[0]  <= IV0;
			h_q[1]  <= IV1;
			h_q[2]  <= IV2;
			h_q[3]  <= IV3;
			h_q[4]  <= IV4;
			fill_q  <= 6'd0;
			total_q <= 64'd0;
		end else begin
			if (cmd.hash_add) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (cmd.put_byte) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.count_byte) begin
				total_q <= total_q + 64'd1;
			end
		end
	end

	// digest readout
	always_comb begin
		unique case (cmd.word_sel)
			3'd0:    digest_word = h_q[0];
			3'd1:    digest_word = h_q[1];
			3'd2:    digest_word = h_q[2];
			3'd3:    digest_word = h_q[3];
			3'd4:    digest_word = h_q[4];
			default: digest_word = h_q[4];
		endcase
	end

endmodule

// ===== src/sha1_digest_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_digest_stream
// SHA-1 over a byte stream; at most one byte per input beat (has_byte), digest out as five
// 32-bit big-endian words.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  data_byte[7:0], has_byte, last_byte
//  out      out_valid/ out_stall digest_word[31:0], word_index[2:0], is_last_word
//
//  byte beats are taken back to back while idle; the 64th byte of a block adds
//  80 rounds and one hash-add step (one round per cycle), with in_stall high
//  a last beat adds padding (marker, zeros, 64-bit length) and one or two compressions,
//  then five output beats; in_stall stays high until the fifth is taken
//  out_stall holds the current digest word; the asynchronous reset loads the
//  initial hash value and clears the counters
// ----------------------------------------------------------------------------
module sha1_digest_stream import sha1ds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        is_last_word
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	sha1ds_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.has_byte     (has_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.word_index   (word_index),
		.is_last_word (is_last_word),
		.cmd          (cmd),
		.status       (status)
	);

	// hashing datapath
	sha1ds_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.status      (status),
		.digest_word (digest_word)
	);

endmodule
